// ----- hdl/pfa_pkg.sv -----
// Shared types and constants of the page frame allocator.
`default_nettype none

package pfa_pkg;

    // Fixed field widths of the request and result channels.
    localparam int FRAME_W = 10;
    localparam int LIMIT_W = 11;
    localparam int COUNT_W = 11;

    // Frame indices are LIMIT_W bits wide, so no frame at or above this span is ever used.
    localparam int FRAME_SPAN = 2 ** LIMIT_W;

    // The used map is stored as rows of WORD_W bits.
    localparam int WORD_W = 32;
    localparam int OFF_W  = 5;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1024);

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef struct packed {
        logic               op;
        logic [FRAME_W-1:0] release_frame;
    } t_pfa_req;

    typedef struct packed {
        logic               ok;
        logic [FRAME_W-1:0] granted_frame;
        logic [COUNT_W-1:0] frames_in_use;
    } t_pfa_res;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic accept;
        logic read;
        logic load;
        logic find;
        logic rchk;
    } t_pfa_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic early_fail;
        logic op_release;
        logic find_again;
        logic find_next;
    } t_pfa_sts;

endpackage

`default_nettype wire

// ----- hdl/pfa_ram.sv -----
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module pfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    input  wire logic                                    i_re,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hdl/pfa_ctrl.sv -----
// Sequencing state machine of the page frame allocator.
`default_nettype none

module pfa_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire pfa_pkg::t_pfa_sts i_sts,
    output pfa_pkg::t_pfa_cmd      o_cmd,
    output logic                   o_busy
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_READ  = 6'b000100,
        S_LOAD  = 6'b001000,
        S_FIND  = 6'b010000,
        S_RCHK  = 6'b100000
    } t_pfa_state;

    t_pfa_state r_state;
    t_pfa_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    if (!i_sts.early_fail) begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = i_sts.op_release ? S_RCHK : S_FIND;
            end
            S_FIND: begin
                o_cmd.find = 1'b1;
                if (i_sts.find_next) begin
                    n_state = S_READ;
                end else if (!i_sts.find_again) begin
                    n_state = S_IDLE;
                end
            end
            S_RCHK: begin
                o_cmd.rchk = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    // A row read is always followed by taking the row into the work register.
    a_read_then_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> (r_state == S_LOAD))
        else $error("row read not followed by load");

    // The search never asks for both another row and another pass on the same row.
    a_find_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIND) |-> !(i_sts.find_next && i_sts.find_again))
        else $error("conflicting search status");

    // Leaving the idle state happens only on an accepted request.
    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !i_start) |=> (r_state == S_IDLE))
        else $error("left idle without a request");

endmodule

`default_nettype wire

// ----- hdl/pfa_dp.sv -----
// Datapath of the page frame allocator: used map, hint, count and row search.
`default_nettype none

module pfa_dp #(
    parameter int MAX_FRAMES = 1024
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire pfa_pkg::t_pfa_cmd                i_cmd,
    output pfa_pkg::t_pfa_sts                     o_sts,
    input  wire pfa_pkg::t_pfa_req                i_req,
    input  wire logic                             i_cfg_we,
    input  wire logic [pfa_pkg::LIMIT_W-1:0]      i_cfg_data,
    output logic                                  o_res_valid,
    output pfa_pkg::t_pfa_res                     o_res
);

    localparam int LW = pfa_pkg::LIMIT_W;
    localparam int OW = pfa_pkg::OFF_W;
    localparam int WW = pfa_pkg::WORD_W;
    localparam int NUM_FRAMES = (MAX_FRAMES < pfa_pkg::FRAME_SPAN) ? MAX_FRAMES
                                                                  : pfa_pkg::FRAME_SPAN;
    localparam int ROWS  = (NUM_FRAMES + WW - 1) / WW;
    localparam int ROW_W = $clog2(ROWS > 1 ? ROWS : 2);

    logic [LW-1:0]                   r_limit;
    logic [LW-1:0]                   r_hint;
    logic [pfa_pkg::COUNT_W-1:0]     r_count;
    logic [LW-1:0]                   r_pos;
    logic                            r_op;
    logic                            r_granted;
    logic [LW-1:0]                   r_gframe;
    logic [WW-1:0]                   r_word;
    logic [ROW_W-1:0]                r_clr_row;
    logic                            r_res_valid;
    pfa_pkg::t_pfa_res               r_res;

    logic [LW-1:0]   lim;
    logic [OW-1:0]   off;
    logic [ROW_W-1:0] row;
    logic [WW-1:0]   low_mask;
    logic [WW-1:0]   free_bits;
    logic            found;
    logic [OW-1:0]   idx;
    logic [LW-1:0]   cand;
    logic            hit;
    logic [LW:0]     next_start;
    logic            more;
    logic            grant_now;
    logic            find_done;
    logic            rel_used;
    logic            rel_commit;
    logic            early_fail;
    logic [WW-1:0]   set_word;
    logic [WW-1:0]   clr_word;
    logic            ram_we;
    logic [ROW_W-1:0] ram_waddr;
    logic [WW-1:0]   ram_wdata;
    logic [WW-1:0]   ram_rdata;

    // Effective limit, saturated at the number of frames held.
    assign lim = ({1'b0, r_limit} > (LW + 1)'(NUM_FRAMES)) ? LW'(NUM_FRAMES) : r_limit;

    assign off = r_pos[OW-1:0];
    assign row = r_pos[OW +: ROW_W];

    // Search the work row for the lowest free frame at or above the scan position.
    assign low_mask  = ~({WW{1'b1}} << off);
    assign free_bits = ~(r_word | low_mask);

    always_comb begin
        found = 1'b0;
        idx   = '0;
        for (int i = WW - 1; i >= 0; i--) begin
            if (free_bits[i]) begin
                found = 1'b1;
                idx   = OW'(i);
            end
        end
    end

    assign cand       = {r_pos[LW-1:OW], idx};
    assign hit        = found && (cand < lim);
    assign next_start = {1'b0, r_pos[LW-1:OW], OW'(0)} + (LW + 1)'(WW);
    assign more       = !hit && (next_start < {1'b0, lim});
    assign grant_now  = i_cmd.find && hit && !r_granted;
    assign find_done  = i_cmd.find && !(hit && !r_granted) && !more;

    assign set_word   = r_word | (WW'(1) << idx);
    assign clr_word   = r_word & ~(WW'(1) << off);
    assign rel_used   = r_word[off];
    assign rel_commit = i_cmd.rchk && rel_used;

    assign early_fail = (i_req.op == pfa_pkg::OP_ALLOC)
                      ? (r_hint >= lim)
                      : ({1'b0, i_req.release_frame} >= lim);

    assign o_sts.clr_last   = (r_clr_row == ROW_W'(ROWS - 1));
    assign o_sts.early_fail = early_fail;
    assign o_sts.op_release = (r_op == pfa_pkg::OP_RELEASE);
    assign o_sts.find_again = hit && !r_granted;
    assign o_sts.find_next  = more;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = row;
        ram_wdata = '0;
        priority if (i_cmd.clear) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_row;
        end else if (grant_now) begin
            ram_we    = 1'b1;
            ram_wdata = set_word;
        end else if (rel_commit) begin
            ram_we    = 1'b1;
            ram_wdata = clr_word;
        end
    end

    pfa_ram #(
        .WIDTH (WW),
        .DEPTH (ROWS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.read),
        .i_raddr (row),
        .o_rdata (ram_rdata)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= pfa_pkg::LIMIT_RESET;
            r_hint      <= '0;
            r_count     <= '0;
            r_clr_row   <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= (i_cmd.accept && early_fail) || find_done || i_cmd.rchk;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            if (i_cmd.clear) begin
                r_clr_row <= r_clr_row + 1'b1;
            end
            if (grant_now) begin
                r_count <= r_count + 1'b1;
            end
            if (find_done) begin
                r_hint <= hit ? cand : lim;
            end
            if (i_cmd.rchk) begin
                if (rel_used) begin
                    if (r_pos < r_hint) begin
                        r_hint <= r_pos;
                    end
                    if (r_count != '0) begin
                        r_count <= r_count - 1'b1;
                    end
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op      <= i_req.op;
            r_pos     <= (i_req.op == pfa_pkg::OP_RELEASE) ? {1'b0, i_req.release_frame}
                                                           : r_hint;
            r_granted <= 1'b0;
            r_res     <= '{ok: 1'b0, granted_frame: '0, frames_in_use: r_count};
        end
        if (i_cmd.load) begin
            r_word <= ram_rdata;
        end
        if (i_cmd.find) begin
            if (grant_now) begin
                r_word    <= set_word;
                r_granted <= 1'b1;
                r_gframe  <= cand;
                r_pos     <= cand;
            end else if (more) begin
                r_pos <= next_start[LW-1:0];
            end
        end
        if (find_done) begin
            r_res.ok            <= r_granted;
            r_res.granted_frame <= r_granted ? r_gframe[pfa_pkg::FRAME_W-1:0] : '0;
            r_res.frames_in_use <= r_count;
        end
        if (i_cmd.rchk) begin
            r_res.ok            <= rel_used;
            r_res.granted_frame <= '0;
            r_res.frames_in_use <= (rel_used && r_count != '0) ? r_count - 1'b1 : r_count;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= pfa_pkg::COUNT_W'(NUM_FRAMES))
        else $error("used count above number of frames");

    a_hint_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_hint} <= (LW + 1)'(NUM_FRAMES))
        else $error("hint beyond number of frames");

    a_grant_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        grant_now |=> (r_count == pfa_pkg::COUNT_W'($past(r_count) + 1'b1)))
        else $error("grant not counted");

endmodule

`default_nettype wire

// ----- hdl/page_frame_allocator.sv -----
// Top level of the page frame allocator.
`default_nettype none

// Physical page frame allocator over a used-bit map with a lowest-free hint.
// A request is taken at a rising edge with start high and busy low; it carries
// an operation (allocate or release) and, for a release, the frame to free.
// Each request gives exactly one result, shown on o_res for a single cycle
// while o_res_valid is high; the receiver cannot hold results off, so it must
// take every strobe as it comes.
// The frame limit is written through its own valid/ready channel, which is
// always ready; it should only be changed while the allocator is idle.
// Sequence: a refused request (no free frame, or a release at or above the
// limit) gives its result in the cycle after acceptance and leaves busy low. A
// release that reads the map steps through row read, load and release check.
// An allocate steps through row read, load and search when the next free
// frame lies in the same 32-frame row, the search granting, then reporting;
// each further row adds a read, load and search on the single map read port.
// After reset the map RAM is cleared one row per cycle, MAX_FRAMES/32 rows
// rounded up, with busy high; limit writes are still taken.
// Reset also sets the limit to 1024 and the hint and used count to zero.
module page_frame_allocator #(
    parameter int MAX_FRAMES = 1024
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire pfa_pkg::t_pfa_req             i_req,
    output logic                               o_res_valid,
    output pfa_pkg::t_pfa_res                  o_res,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [pfa_pkg::LIMIT_W-1:0]   i_cfg_data
);

    pfa_pkg::t_pfa_cmd cmd;
    pfa_pkg::t_pfa_sts sts;

    // The limit register can be written in any cycle.
    assign o_cfg_ready = 1'b1;

    // The controller only sequences; every decision about the map is taken in
    // the datapath and reported back as status.
    pfa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    pfa_dp #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire
